>>> rtl/core/normal_texture_histogram_macros.svh
// Assertion macros shared by the histogram block checkers.
`ifndef NORMAL_TEXTURE_HISTOGRAM_MACROS_SVH
`define NORMAL_TEXTURE_HISTOGRAM_MACROS_SVH

// Implication checked in the same cycle, masked during reset.
`define NTH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle, masked during reset.
`define NTH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked in the same cycle, live through reset.
`define NTH_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/nth_pkg.sv
// Shared types, codes and distance thresholds of the normal texture histogram.
package nth_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_NBR_DEF    = 16;
  localparam int NUM_SIZES_DEF  = 4;
  localparam int COUNT_BITS_DEF = 32;

  // Number of neighborhood size registers
  localparam int SIZE_REGS = 4;

  // Bins per metric
  localparam int BINS16 = 65536;
  localparam int BINS12 = 4096;
  localparam int BINS8  = 256;

  // Command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // Metric codes for read commands
  localparam logic [1:0] MET_D16 = 2'd0;
  localparam logic [1:0] MET_D12 = 2'd1;
  localparam logic [1:0] MET_OCT = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_SIZE_A    = 3'd0;
  localparam logic [2:0] REG_SIZE_B    = 3'd1;
  localparam logic [2:0] REG_SIZE_C    = 3'd2;
  localparam logic [2:0] REG_SIZE_D    = 3'd3;
  localparam logic [2:0] REG_SIZES_USE = 3'd4;
  localparam logic [2:0] REG_METRIC_EN = 3'd5;

  // Bin edges in thousandths
  localparam int unsigned EDGE16_MILLI [17] = '{
    50, 100, 175, 275, 400, 525, 650, 775, 900,
    1025, 1150, 1275, 1400, 1525, 1650, 1800, 2000
  };
  localparam int unsigned EDGE12_MILLI [13] = '{
    50, 100, 300, 450, 600, 750, 900, 1050, 1200, 1350, 1550, 1750, 2000
  };

  // Squared edge in Q2.28, rounded up; only ever called on constants
  function automatic logic [63:0] sq_thr(input int unsigned milli);
    logic [63:0] m;
    m = 64'(milli);
    return (m * m * 64'd268435456 + 64'd999999) / 64'd1000000;
  endfunction

  // One histogram job: a set of sizes to count, or a single bin read
  typedef struct packed {
    logic                 is_read;
    logic [SIZE_REGS-1:0] mask;
    logic [15:0]          l16;
    logic [11:0]          l12;
    logic [7:0]           l8;
    logic [2:0]           men;
    logic [1:0]           rmetric;
    logic [1:0]           rsize;
    logic [15:0]          rbin;
  } job_t;

endpackage

>>> rtl/core/nth_bank.sv
// One histogram memory with read-modify-write, saturating increment and forwarding.
module nth_bank #(
  parameter int W     = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clr_en,
  input  logic [AW-1:0] clr_addr,
  input  logic          req_en,
  input  logic          req_inc,
  input  logic [AW-1:0] req_addr,
  output logic [W-1:0]  q
);

  logic [W-1:0]  mem [DEPTH];
  logic [W-1:0]  mem_q;
  logic          p_valid;
  logic          p_inc;
  logic [AW-1:0] p_addr;
  logic          p_hit;
  logic [W-1:0]  wb_data;
  logic [W-1:0]  cur;
  logic [W-1:0]  upd;

  // current value: last write-back wins over the stale memory word
  assign cur = p_hit ? wb_data : mem_q;
  assign q   = cur;
  assign upd = (cur == {W{1'b1}}) ? cur : cur + W'(1);

  // memory array: clear sweep or write-back, registered read
  always_ff @(posedge clk) begin
    if (clr_en) begin
      mem[clr_addr] <= '0;
    end else if (p_valid && p_inc) begin
      mem[p_addr] <= upd;
    end
    if (req_en) begin
      mem_q <= mem[req_addr];
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      p_hit   <= 1'b0;
    end else begin
      p_valid <= req_en;
      p_hit   <= req_en && p_valid && p_inc && (p_addr == req_addr);
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (req_en) begin
      p_inc  <= req_inc;
      p_addr <= req_addr;
    end
    if (p_valid && p_inc) begin
      wb_data <= upd;
    end
  end

endmodule

>>> rtl/core/nth_front.sv
// Front stage: squared normal distance, running labels and size firing per point.
module nth_front #(
  parameter int MAX_NBR   = nth_pkg::MAX_NBR_DEF,
  parameter int NUM_SIZES = nth_pkg::NUM_SIZES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 take,
  input  logic                                 go,
  input  logic                                 cmd,
  input  logic signed [15:0]                   centre_nx,
  input  logic signed [15:0]                   centre_ny,
  input  logic signed [15:0]                   centre_nz,
  input  logic signed [15:0]                   nbr_nx,
  input  logic signed [15:0]                   nbr_ny,
  input  logic signed [15:0]                   nbr_nz,
  input  logic                                 last_nbr,
  input  logic [1:0]                           read_metric,
  input  logic [1:0]                           read_size,
  input  logic [15:0]                          read_bin,
  input  logic [nth_pkg::SIZE_REGS-1:0][4:0]   sizes,
  input  logic [2:0]                           sizes_in_use,
  input  logic [2:0]                           metric_enable,
  output logic                                 p1_valid,
  output logic                                 has_job,
  output nth_pkg::job_t                        job
);

  localparam int SW = $clog2(MAX_NBR + 1);

  logic               p1_cmd;
  logic [31:0]        sq_x, sq_y, sq_z;
  logic [2:0]         p1_sign;
  logic               p1_last;
  logic [1:0]         p1_rmetric, p1_rsize;
  logic [15:0]        p1_rbin;

  logic signed [16:0] dx, dy, dz;
  logic signed [33:0] px, py, pz;

  logic [15:0]        dist16_label;
  logic [11:0]        dist12_label;
  logic [7:0]         octant_label;
  logic [SW-1:0]      nbr_seen;
  logic [nth_pkg::SIZE_REGS-1:0] sizes_done;

  logic [33:0]        d2;
  logic [15:0]        bit16;
  logic [11:0]        bit12;
  logic [15:0]        l16_next;
  logic [11:0]        l12_next;
  logic [7:0]         l8_next;
  logic [SW-1:0]      seen_next;
  logic [nth_pkg::SIZE_REGS-1:0] fire;
  int                 active;
  int                 eff;

  // differences and squares of the accepted item
  assign dx = {centre_nx[15], centre_nx} - {nbr_nx[15], nbr_nx};
  assign dy = {centre_ny[15], centre_ny} - {nbr_ny[15], nbr_ny};
  assign dz = {centre_nz[15], centre_nz} - {nbr_nz[15], nbr_nz};
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (take) begin
      p1_valid <= 1'b1;
    end else if (go) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p1_cmd     <= cmd;
      sq_x       <= px[31:0];
      sq_y       <= py[31:0];
      sq_z       <= pz[31:0];
      p1_sign    <= {~nbr_nx[15], ~nbr_ny[15], ~nbr_nz[15]};
      p1_last    <= last_nbr;
      p1_rmetric <= read_metric;
      p1_rsize   <= read_size;
      p1_rbin    <= read_bin;
    end
  end

  // distance bins against squared edges
  always_comb begin
    d2 = 34'(sq_x) + 34'(sq_y) + 34'(sq_z);
    for (int i = 0; i < 16; i++) begin
      bit16[i] = (d2 >= 34'(nth_pkg::sq_thr(nth_pkg::EDGE16_MILLI[i]))) &&
                 (d2 <  34'(nth_pkg::sq_thr(nth_pkg::EDGE16_MILLI[i+1])));
    end
    for (int i = 0; i < 12; i++) begin
      bit12[i] = (d2 >= 34'(nth_pkg::sq_thr(nth_pkg::EDGE12_MILLI[i]))) &&
                 (d2 <  34'(nth_pkg::sq_thr(nth_pkg::EDGE12_MILLI[i+1])));
    end
  end

  // label update, neighbor count and sizes that count now
  always_comb begin
    l16_next  = dist16_label | bit16;
    l12_next  = dist12_label | bit12;
    l8_next   = octant_label | (8'd1 << p1_sign);
    seen_next = (int'(nbr_seen) < MAX_NBR) ? nbr_seen + SW'(1) : nbr_seen;
    active    = int'(sizes_in_use);
    if (active > NUM_SIZES) active = NUM_SIZES;
    if (active > nth_pkg::SIZE_REGS) active = nth_pkg::SIZE_REGS;
    fire = '0;
    for (int s = 0; s < nth_pkg::SIZE_REGS; s++) begin
      eff = (int'(sizes[s]) > MAX_NBR) ? MAX_NBR : int'(sizes[s]);
      fire[s] = (s < active) && !sizes_done[s] &&
                ((int'(seen_next) == eff) || p1_last);
    end
  end

  // point state
  always_ff @(posedge clk) begin
    if (rst) begin
      dist16_label <= '0;
      dist12_label <= '0;
      octant_label <= '0;
      nbr_seen     <= '0;
      sizes_done   <= '0;
    end else if (go && (p1_cmd == nth_pkg::CMD_SAMPLE)) begin
      if (p1_last) begin
        dist16_label <= '0;
        dist12_label <= '0;
        octant_label <= '0;
        nbr_seen     <= '0;
        sizes_done   <= '0;
      end else begin
        dist16_label <= l16_next;
        dist12_label <= l12_next;
        octant_label <= l8_next;
        nbr_seen     <= seen_next;
        sizes_done   <= sizes_done | fire;
      end
    end
  end

  // job handed to the histogram engine
  always_comb begin
    has_job     = (p1_cmd == nth_pkg::CMD_READ) || (|fire);
    job.is_read = (p1_cmd == nth_pkg::CMD_READ);
    job.mask    = (p1_cmd == nth_pkg::CMD_READ) ? '0 : fire;
    job.l16     = l16_next;
    job.l12     = l12_next;
    job.l8      = l8_next;
    job.men     = metric_enable;
    job.rmetric = p1_rmetric;
    job.rsize   = p1_rsize;
    job.rbin    = p1_rbin;
  end

endmodule

>>> rtl/core/normal_texture_histogram.sv
// Normal texture histogram: labels neighbors of a point by normal distance and sign
// octant and counts each point's labels in per-size histograms held in three
// simple dual-port memories (one read and one write port each). After reset a
// clearing pass over all NUM_SIZES*65536 addresses zeroes the memories; in_stall
// stays high through it. Samples that close neighborhood sizes stall the input while
// the histogram engine does one read-modify-write per size per cycle. A read command
// goes through the front stage, the job register, the memory read register and the
// output word register; it waits while the previous read fills the read-result
// stage or a stalled word holds the single output register.
module normal_texture_histogram #(
  parameter int MAX_NBR    = nth_pkg::MAX_NBR_DEF,
  parameter int NUM_SIZES  = nth_pkg::NUM_SIZES_DEF,
  parameter int COUNT_BITS = nth_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic signed [15:0] centre_nx,
  input  logic signed [15:0] centre_ny,
  input  logic signed [15:0] centre_nz,
  input  logic signed [15:0] nbr_nx,
  input  logic signed [15:0] nbr_ny,
  input  logic signed [15:0] nbr_nz,
  input  logic               last_nbr,
  input  logic [1:0]         read_metric,
  input  logic [1:0]         read_size,
  input  logic [15:0]        read_bin,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        bin_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [4:0]         cfg_data
);

  localparam int D16 = NUM_SIZES * nth_pkg::BINS16;
  localparam int D12 = NUM_SIZES * nth_pkg::BINS12;
  localparam int D8  = NUM_SIZES * nth_pkg::BINS8;
  localparam int A16 = $clog2(D16);
  localparam int A12 = $clog2(D12);
  localparam int A8  = $clog2(D8);

  // configuration registers
  logic [nth_pkg::SIZE_REGS-1:0][4:0] sizes;
  logic [2:0] sizes_in_use;
  logic [2:0] metric_enable;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < nth_pkg::SIZE_REGS; i++) sizes[i] <= 5'd8;
      sizes_in_use  <= 3'd1;
      metric_enable <= 3'd7;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nth_pkg::REG_SIZE_A:    sizes[0]      <= cfg_data;
        nth_pkg::REG_SIZE_B:    sizes[1]      <= cfg_data;
        nth_pkg::REG_SIZE_C:    sizes[2]      <= cfg_data;
        nth_pkg::REG_SIZE_D:    sizes[3]      <= cfg_data;
        nth_pkg::REG_SIZES_USE: sizes_in_use  <= cfg_data[2:0];
        nth_pkg::REG_METRIC_EN: metric_enable <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // clearing sweep after reset
  logic           clearing;
  logic [A16-1:0] clr_ctr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_ctr  <= '0;
    end else if (clearing) begin
      clr_ctr <= clr_ctr + A16'(1);
      if (clr_ctr == A16'(D16 - 1)) clearing <= 1'b0;
    end
  end

  // front stage
  logic          p1_valid;
  logic          has_job;
  logic          go;
  logic          take;
  nth_pkg::job_t job_in;

  assign in_stall = clearing || (p1_valid && !go);
  assign take     = in_valid && !in_stall;

  nth_front #(
    .MAX_NBR   (MAX_NBR),
    .NUM_SIZES (NUM_SIZES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .go            (go),
    .cmd           (cmd),
    .centre_nx     (centre_nx),
    .centre_ny     (centre_ny),
    .centre_nz     (centre_nz),
    .nbr_nx        (nbr_nx),
    .nbr_ny        (nbr_ny),
    .nbr_nz        (nbr_nz),
    .last_nbr      (last_nbr),
    .read_metric   (read_metric),
    .read_size     (read_size),
    .read_bin      (read_bin),
    .sizes         (sizes),
    .sizes_in_use  (sizes_in_use),
    .metric_enable (metric_enable),
    .p1_valid      (p1_valid),
    .has_job       (has_job),
    .job           (job_in)
  );

  // histogram engine: one size or one read per cycle, reads held by a busy result path
  logic          job_valid;
  nth_pkg::job_t job;
  logic          rv;
  logic          r_zero;
  logic [1:0]    r_metric;
  logic          read_ok;
  logic          issue;
  logic          job_done;
  logic [nth_pkg::SIZE_REGS-1:0] low_bit;
  logic [1:0]    s_idx;
  logic          rd_bad;
  logic          en16, en12, en8;
  logic [A16-1:0] a16;
  logic [A12-1:0] a12;
  logic [A8-1:0]  a8;

  assign read_ok = !rv && (!out_valid || !out_stall);
  assign low_bit = job.mask & (~job.mask + nth_pkg::SIZE_REGS'(1));
  assign rd_bad  = (int'(job.rsize) >= NUM_SIZES) ||
                   ((job.rmetric == nth_pkg::MET_D12) && (job.rbin >= 16'(nth_pkg::BINS12))) ||
                   ((job.rmetric == nth_pkg::MET_OCT) && (job.rbin >= 16'(nth_pkg::BINS8))) ||
                   ((job.rmetric != nth_pkg::MET_D16) && (job.rmetric != nth_pkg::MET_D12) &&
                    (job.rmetric != nth_pkg::MET_OCT));

  always_comb begin
    s_idx = '0;
    for (int i = nth_pkg::SIZE_REGS - 1; i >= 0; i--) begin
      if (job.mask[i]) s_idx = 2'(i);
    end
  end

  always_comb begin
    issue    = 1'b0;
    job_done = 1'b0;
    en16     = 1'b0;
    en12     = 1'b0;
    en8      = 1'b0;
    a16      = A16'({s_idx, job.l16});
    a12      = A12'({s_idx, job.l12});
    a8       = A8'({s_idx, job.l8});
    if (job_valid) begin
      if (job.is_read) begin
        issue    = read_ok;
        job_done = read_ok;
        a16      = A16'({job.rsize, job.rbin});
        a12      = A12'({job.rsize, job.rbin[11:0]});
        a8       = A8'({job.rsize, job.rbin[7:0]});
        en16     = read_ok && !rd_bad && (job.rmetric == nth_pkg::MET_D16);
        en12     = read_ok && !rd_bad && (job.rmetric == nth_pkg::MET_D12);
        en8      = read_ok && !rd_bad && (job.rmetric == nth_pkg::MET_OCT);
      end else begin
        issue    = 1'b1;
        job_done = (job.mask & ~low_bit) == '0;
        en16     = job.men[0];
        en12     = job.men[1];
        en8      = job.men[2];
      end
    end
  end

  assign go = p1_valid && (!job_valid || job_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (go) begin
      job_valid <= has_job;
    end else if (job_done) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      job <= job_in;
    end else if (issue && !job.is_read) begin
      job.mask <= job.mask & ~low_bit;
    end
  end

  // read-result stage bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else begin
      rv <= issue && job.is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && job.is_read) begin
      r_zero   <= rd_bad;
      r_metric <= job.rmetric;
    end
  end

  // memories
  logic [COUNT_BITS-1:0] q16, q12, q8;
  logic [A16-1:0] clr16;
  logic [A12-1:0] clr12;
  logic [A8-1:0]  clr8;

  assign clr16 = clr_ctr;
  assign clr12 = A12'(clr_ctr);
  assign clr8  = A8'(clr_ctr);

  nth_bank #(.W(COUNT_BITS), .DEPTH(D16), .AW(A16)) u_bank16 (
    .clk      (clk),
    .rst      (rst),
    .clr_en   (clearing),
    .clr_addr (clr16),
    .req_en   (en16),
    .req_inc  (!job.is_read),
    .req_addr (a16),
    .q        (q16)
  );

  nth_bank #(.W(COUNT_BITS), .DEPTH(D12), .AW(A12)) u_bank12 (
    .clk      (clk),
    .rst      (rst),
    .clr_en   (clearing && (int'(clr_ctr) < D12)),
    .clr_addr (clr12),
    .req_en   (en12),
    .req_inc  (!job.is_read),
    .req_addr (a12),
    .q        (q12)
  );

  nth_bank #(.W(COUNT_BITS), .DEPTH(D8), .AW(A8)) u_bank8 (
    .clk      (clk),
    .rst      (rst),
    .clr_en   (clearing && (int'(clr_ctr) < D8)),
    .clr_addr (clr8),
    .req_en   (en8),
    .req_inc  (!job.is_read),
    .req_addr (a8),
    .q        (q8)
  );

  // output word register
  logic [COUNT_BITS-1:0] sel_q;
  logic [63:0]           sel_wide;

  always_comb begin
    unique case (r_metric)
      nth_pkg::MET_D16: sel_q = q16;
      nth_pkg::MET_D12: sel_q = q12;
      nth_pkg::MET_OCT: sel_q = q8;
      default:          sel_q = '0;
    endcase
    sel_wide = r_zero ? 64'd0 : 64'(sel_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rv) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rv) begin
      bin_count <= sel_wide[31:0];
    end
  end

endmodule

>>> rtl/core/nth_checker.sv
// Port-level checker for the normal texture histogram, bound to the top level.
`include "normal_texture_histogram_macros.svh"

module nth_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] bin_count,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // a stalled result word holds
  `NTH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(bin_count), "result word changed while stalled")

  // the clearing sweep keeps input closed right after reset
  `NTH_ASSERT_RST(a_clear_stall, !rst && $past(rst), in_stall, "input open before clearing finished")

  // no result word straight out of reset
  `NTH_ASSERT_RST(a_no_early_out, !rst && $past(rst), !out_valid, "result word right after reset")

  // configuration writes are never refused
  `NTH_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind normal_texture_histogram nth_checker u_nth_checker (.*);

>>> bench/tb_top.sv
// Self-checking testbench for the normal texture histogram block.
module tb_top;

  localparam int MAXN = 16;
  localparam int NSZ = 4;
  localparam int LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = nth_pkg::CMD_SAMPLE;
  logic signed [15:0] centre_nx = '0, centre_ny = '0, centre_nz = '0;
  logic signed [15:0] nbr_nx = '0, nbr_ny = '0, nbr_nz = '0;
  logic last_nbr = 1'b0;
  logic [1:0] read_metric = nth_pkg::MET_D16;
  logic [1:0] read_size = '0;
  logic [15:0] read_bin = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] bin_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = nth_pkg::REG_SIZE_A;
  logic [4:0] cfg_data = '0;

  normal_texture_histogram u_dut (.*);

  always #6 clk = ~clk;

  // shadow of the block: config, point labels and histograms
  logic [4:0] size_reg [4];
  logic [2:0] sizes_used, metric_en;
  logic [15:0] lab16;
  logic [11:0] lab12;
  logic [7:0] lab8;
  logic [4:0] nbrs_seen;
  logic [3:0] done_mask;
  logic [31:0] cnt16 [int];
  logic [31:0] cnt12 [int];
  logic [31:0] cnt8 [int];
  logic [63:0] thr16 [17];
  logic [63:0] thr12 [13];
  logic [31:0] pending_counts [$];
  int touched_met [$], touched_sz [$], touched_bin [$];

  int mismatches = 0, cycles = 0, n_samples = 0, n_reads = 0, n_checked = 0;
  bit calm_send = 0, calm_recv = 0, hold_req = 0;
  int hold_left = 0, stall_left = 0;

  function automatic logic [63:0] edge_sq(int unsigned milli);
    logic [63:0] m;
    m = 64'(milli);
    return (m * m * 64'd268435456 + 64'd999999) / 64'd1000000;
  endfunction

  function automatic logic [15:0] band16(logic [63:0] d2);
    for (int i = 0; i < 16; i++)
      if (d2 >= thr16[i] && d2 < thr16[i+1]) return 16'(1) << i;
    return '0;
  endfunction

  function automatic logic [11:0] band12(logic [63:0] d2);
    for (int i = 0; i < 12; i++)
      if (d2 >= thr12[i] && d2 < thr12[i+1]) return 12'(1) << i;
    return '0;
  endfunction

  function automatic logic [31:0] bump(logic [31:0] c);
    return (c == 32'hffff_ffff) ? c : c + 1;
  endfunction

  // fold one accepted word into the shadow state
  task automatic absorb_word();
    logic signed [63:0] dx, dy, dz;
    logic [63:0] d2;
    int act, eff, k;
    if (cmd == nth_pkg::CMD_READ) begin
      logic [31:0] v;
      v = '0;
      k = int'(read_size);
      if (read_metric == nth_pkg::MET_D16 && cnt16.exists(k*65536 + read_bin))
        v = cnt16[k*65536 + read_bin];
      if (read_metric == nth_pkg::MET_D12 && read_bin < 4096 && cnt12.exists(k*4096 + read_bin))
        v = cnt12[k*4096 + read_bin];
      if (read_metric == nth_pkg::MET_OCT && read_bin < 256 && cnt8.exists(k*256 + read_bin))
        v = cnt8[k*256 + read_bin];
      pending_counts.push_back(v);
      n_reads++;
      return;
    end
    n_samples++;
    dx = 64'(centre_nx) - 64'(nbr_nx);
    dy = 64'(centre_ny) - 64'(nbr_ny);
    dz = 64'(centre_nz) - 64'(nbr_nz);
    d2 = dx*dx + dy*dy + dz*dz;
    lab16 |= band16(d2);
    lab12 |= band12(d2);
    lab8 |= 8'(1) << {nbr_nx >= 0, nbr_ny >= 0, nbr_nz >= 0};
    if (nbrs_seen < MAXN) nbrs_seen++;
    act = (sizes_used > NSZ) ? NSZ : sizes_used;
    for (int s = 0; s < act; s++) begin
      eff = (size_reg[s] > MAXN) ? MAXN : size_reg[s];
      if (done_mask[s]) continue;
      if (nbrs_seen == eff || last_nbr) begin
        if (metric_en[0]) begin
          k = s*65536 + lab16;
          cnt16[k] = bump(cnt16.exists(k) ? cnt16[k] : 0);
          touched_met.push_back(nth_pkg::MET_D16); touched_sz.push_back(s);
          touched_bin.push_back(lab16);
        end
        if (metric_en[1]) begin
          k = s*4096 + lab12;
          cnt12[k] = bump(cnt12.exists(k) ? cnt12[k] : 0);
          touched_met.push_back(nth_pkg::MET_D12); touched_sz.push_back(s);
          touched_bin.push_back(lab12);
        end
        if (metric_en[2]) begin
          k = s*256 + lab8;
          cnt8[k] = bump(cnt8.exists(k) ? cnt8[k] : 0);
          touched_met.push_back(nth_pkg::MET_OCT); touched_sz.push_back(s);
          touched_bin.push_back(lab8);
        end
        done_mask[s] = 1'b1;
      end
    end
    if (last_nbr) begin
      lab16 = '0; lab12 = '0; lab8 = '0; nbrs_seen = '0; done_mask = '0;
    end
  endtask

  // drive one word (caller sits at a falling edge), wait for acceptance, then maybe idle
  task automatic send_word();
    int r, gap;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    absorb_word();
    @(negedge clk);
    r = $urandom_range(0, 99);
    gap = (calm_send || r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_sample(logic signed [15:0] cx, cy, cz, nx, ny, nz, logic lst);
    cmd = nth_pkg::CMD_SAMPLE;
    centre_nx = cx; centre_ny = cy; centre_nz = cz;
    nbr_nx = nx; nbr_ny = ny; nbr_nz = nz;
    last_nbr = lst;
    read_metric = 2'($urandom); read_size = 2'($urandom); read_bin = 16'($urandom);
    send_word();
  endtask

  task automatic send_read(logic [1:0] met, logic [1:0] sz, logic [15:0] bn);
    cmd = nth_pkg::CMD_READ;
    read_metric = met; read_size = sz; read_bin = bn;
    last_nbr = 1'($urandom);
    centre_nx = 16'($urandom); nbr_nz = 16'($urandom);
    send_word();
  endtask

  // read a bin that has been counted, or now and then any bin at all
  task automatic send_random_read();
    int i;
    if (touched_bin.size() > 0 && $urandom_range(0, 99) < 70) begin
      i = $urandom_range(0, touched_bin.size() - 1);
      send_read(2'(touched_met[i]), 2'(touched_sz[i]), 16'(touched_bin[i]));
    end else
      send_read(2'($urandom), 2'($urandom), 16'($urandom));
  endtask

  function automatic logic signed [15:0] rand_axis();
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  function automatic logic signed [15:0] near_axis(logic signed [15:0] c, int span);
    int v;
    v = int'(c) + $urandom_range(0, 2*span) - span;
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return 16'(v);
  endfunction

  // one point: a run of neighbors around a random centre, closed by last_nbr
  task automatic send_point(int nbrs);
    logic signed [15:0] cx, cy, cz;
    int span;
    cx = rand_axis(); cy = rand_axis(); cz = rand_axis();
    for (int i = 0; i < nbrs; i++) begin
      span = (i % 3 == 0) ? 32768 : 1 << $urandom_range(5, 14);
      send_sample(cx, cy, cz, near_axis(cx, span), near_axis(cy, span), near_axis(cz, span),
                  i == nbrs - 1);
      if ($urandom_range(0, 99) < 8) send_random_read();
    end
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_counts.size() > 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [4:0] val);
    cfg_valid = 1'b1; cfg_index = idx; cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= nth_pkg::REG_SIZE_D) size_reg[idx] = val;
    else if (idx == nth_pkg::REG_SIZES_USE) sizes_used = val[2:0];
    else if (idx == nth_pkg::REG_METRIC_EN) metric_en = val[2:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(logic [4:0] a, b, c, d, logic [2:0] use_n, men);
    wait_idle();
    write_reg(nth_pkg::REG_SIZE_A, a);
    write_reg(nth_pkg::REG_SIZE_B, b);
    write_reg(nth_pkg::REG_SIZE_C, c);
    write_reg(nth_pkg::REG_SIZE_D, d);
    write_reg(nth_pkg::REG_SIZES_USE, 5'(use_n));
    write_reg(nth_pkg::REG_METRIC_EN, 5'(men));
  endtask

  // extremes of the normals, octants, zero distance, over-range distance, odd reads
  task automatic test_directed();
    send_sample(16384, 16384, 16384, -16384, -16384, -16384, 1'b0);
    send_sample(0, 0, 0, 0, 0, 0, 1'b0);
    send_sample(-16384, 0, 16384, -16384, 0, 16384, 1'b0);
    send_sample(0, 0, 0, 819, 0, 0, 1'b0);
    send_sample(0, 0, 0, 820, 0, 0, 1'b0);
    send_sample(0, 0, 0, -1, 16384, -16384, 1'b0);
    send_sample(16384, 0, 0, -16384, 0, 0, 1'b0);
    send_sample(0, 0, 0, 1, -1, 1, 1'b1);
    send_sample(100, 200, -300, -5000, 7000, 2, 1'b1);
    send_read(nth_pkg::MET_OCT, 2'd0, 16'h00ff);
    send_read(nth_pkg::MET_OCT, 2'd0, 16'd256);
    send_read(nth_pkg::MET_D12, 2'd0, 16'd4096);
    send_read(nth_pkg::MET_D16, 2'd3, 16'hffff);
    send_read(2'd3, 2'd0, 16'd0);
    for (int i = 0; i < 6; i++) send_random_read();
  endtask

  task automatic test_random_phase(int points, int max_nbrs);
    for (int p = 0; p < points; p++) begin
      calm_send = ($urandom_range(0, 9) == 0);
      send_point($urandom_range(1, max_nbrs));
      if ($urandom_range(0, 3) == 0) send_random_read();
    end
    calm_send = 0;
  endtask

  // receiver holds off for a long stretch while reads keep coming
  task automatic test_backpressure();
    hold_req = 1;
    calm_send = 1;
    for (int i = 0; i < 40; i++) send_random_read();
    calm_send = 0;
  endtask

  // receiver side: random stalls, quiet stretches and one long hold
  always @(negedge clk) begin
    if (rst) begin
      out_stall = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left = 300;
      out_stall = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (r == 0) calm_recv = ~calm_recv;
      if (calm_recv || r < 70) out_stall = 1'b0;
      else begin
        out_stall = 1'b1;
        stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  // compare each word leaving the block with the oldest expected count
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: bin_count=%0d", bin_count);
      end else begin
        logic [31:0] want;
        want = pending_counts.pop_front();
        n_checked++;
        if (bin_count !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("bin_count mismatch: expected %0d got %0d", want, bin_count);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d counts outstanding", cycles, pending_counts.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 17; i++) thr16[i] = edge_sq(nth_pkg::EDGE16_MILLI[i]);
    for (int i = 0; i < 13; i++) thr12[i] = edge_sq(nth_pkg::EDGE12_MILLI[i]);
    for (int i = 0; i < 4; i++) size_reg[i] = 5'd8;
    sizes_used = 3'd1; metric_en = 3'd7;
    lab16 = '0; lab12 = '0; lab8 = '0; nbrs_seen = '0; done_mask = '0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_phase(20, 12);
    set_config(5'd1, 5'd16, 5'd31, 5'd0, 3'd7, 3'd7);
    test_random_phase(30, 20);
    set_config(5'd3, 5'd5, 5'd9, 5'd16, 3'd4, 3'd5);
    test_random_phase(30, 18);
    test_backpressure();
    set_config(5'd2, 5'd4, 5'd6, 5'd8, 3'd0, 3'd0);
    test_random_phase(8, 10);
    set_config(5'd16, 5'd1, 5'd2, 5'd17, 3'd2, 3'd2);
    test_random_phase(20, 20);
    set_config(5'd4, 5'd8, 5'd12, 5'd16, 3'd3, 3'd6);
    test_random_phase(30, 18);
    set_config(5'd5, 5'd10, 5'd15, 5'd20, 3'd4, 3'd7);
    test_random_phase(20, 18);
    wait_idle();
    for (int i = 0; i < 60; i++) send_random_read();
    wait_idle();

    $display("covered %0d neighbor samples and %0d bin reads over seven register settings",
             n_samples, n_reads);
    $display("%0d counts checked, %0d mismatches", n_checked, mismatches);
    if (mismatches == 0 && pending_counts.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
